// File: sv/dtdn_pkg.sv
// Shared types, calendar tables and constant-divisor helpers for the date converter.
package dtdn_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 7;
  localparam int DAY_W   = 7;
  localparam int DNUM_W  = 22;
  localparam int LEAPS_W = 12;

  localparam logic [YEAR_W-1:0]  YEAR_BASE    = 14'd1900;
  localparam logic [MONTH_W-1:0] MONTH_FIRST  = 7'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST   = 7'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 7'd2;
  // Leap-year counts of 1899 folded together: 474 - 18 + 4 - 0.
  localparam logic [LEAPS_W-1:0] LEAPS_OFFSET = 12'd460;

  typedef struct packed {
    logic               leap;
    logic [LEAPS_W-1:0] leaps_before;
  } year_info_t;

  typedef struct packed {
    logic              date_valid;
    logic [DNUM_W-1:0] day_number;
  } result_t;

  // x / 25 for x below 4096, by reciprocal multiplication.
  function automatic logic [7:0] div25(input logic [11:0] x);
    logic [24:0] prod;
    prod = {13'd0, x} * 25'd5243;
    return prod[24:17];
  endfunction

  // x / 125 for x below 512, by reciprocal multiplication.
  function automatic logic [2:0] div125(input logic [8:0] x);
    logic [18:0] prod;
    prod = {10'd0, x} * 19'd525;
    return prod[18:16];
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    case (m)
      4'd1:    return 9'd0;
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] m);
    case (m)
      4'd2:    return 5'd28;
      4'd4:    return 5'd30;
      4'd6:    return 5'd30;
      4'd9:    return 5'd30;
      4'd11:   return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

endpackage

// File: sv/dtdn_if.sv
// Valid/ready channel interfaces for dates in and day numbers out.
interface dtdn_date_if
  import dtdn_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;

  modport source (output valid, output year, output month, output day, input ready);
  modport sink   (input valid, input year, input month, input day, output ready);
endinterface

interface dtdn_result_if
  import dtdn_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              date_valid;
  logic [DNUM_W-1:0] day_number;

  modport source (output valid, output date_valid, output day_number, input ready);
  modport sink   (input valid, input date_valid, input day_number, output ready);
endinterface

// File: sv/date_to_day_number.sv
// Top level: registered date in, registered serial day number out.
//
//   channel  role    payload
//   req      sink    year[13:0], month[6:0], day[6:0]
//   rsp      source  date_valid, day_number[21:0]
//
// Each beat passes through the input register, then through the check and
// count logic into the result register. A new date is accepted every cycle
// while the result side drains. A stalled result holds both registers; req
// stays ready while the input register is empty. Synchronous reset clears
// both valid flags.
module date_to_day_number
  import dtdn_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  dtdn_date_if.sink      req,
  dtdn_result_if.source  rsp
);

  logic               in_valid;
  logic [YEAR_W-1:0]  in_year;
  logic [MONTH_W-1:0] in_month;
  logic [DAY_W-1:0]   in_day;
  logic               out_valid;
  result_t            out_result;
  result_t            core_result;
  logic               advance;

  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !in_valid || advance;

  dtdn_core u_core (
    .year   (in_year),
    .month  (in_month),
    .day    (in_day),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        in_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_year  <= req.year;
      in_month <= req.month;
      in_day   <= req.day;
    end
    if (advance && in_valid) begin
      out_result <= core_result;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.date_valid = out_result.date_valid;
  assign rsp.day_number = out_result.day_number;

endmodule

// File: sv/dtdn_leap.sv
// Leap flag of a year and the count of leap years from 1900 up to the year before it.
module dtdn_leap
  import dtdn_pkg::*;
(
  input  logic [YEAR_W-1:0] year,
  output year_info_t        info
);

  logic [YEAR_W-1:0] prev;
  logic [7:0]        y100, y400, p100, p400;
  logic [2:0]        y4000, p4000;
  logic              d4, d100, d400, d4000;

  always_comb begin
    prev  = year - YEAR_W'(1);

    y100  = div25(year[YEAR_W-1:2]);
    y400  = div25({2'd0, year[YEAR_W-1:4]});
    y4000 = div125(year[YEAR_W-1:5]);
    p100  = div25(prev[YEAR_W-1:2]);
    p400  = div25({2'd0, prev[YEAR_W-1:4]});
    p4000 = div125(prev[YEAR_W-1:5]);

    // A year is a multiple when it equals its quotient times the divisor.
    d4    = (year[1:0] == 2'd0);
    d100  = ({1'b0, year} == {7'd0, y100} * 15'd100);
    d400  = ({3'b0, year} == {9'd0, y400} * 17'd400);
    d4000 = ({2'b0, year} == {13'd0, y4000} * 16'd4000);

    info.leap = !d4000 && (d400 || (!d100 && d4));
    info.leaps_before = prev[YEAR_W-1:2] - {4'd0, p100} + {4'd0, p400}
                      - {9'd0, p4000} - LEAPS_OFFSET;
  end

endmodule

// File: sv/dtdn_core.sv
// Date check and serial day count for one registered date.
module dtdn_core
  import dtdn_pkg::*;
(
  input  logic [YEAR_W-1:0]  year,
  input  logic [MONTH_W-1:0] month,
  input  logic [DAY_W-1:0]   day,
  output result_t            result
);

  year_info_t        info;
  logic              month_ok;
  logic [3:0]        m;
  logic [4:0]        mdays;
  logic              ok;
  logic [DNUM_W-1:0] total;

  dtdn_leap u_leap (
    .year (year),
    .info (info)
  );

  always_comb begin
    month_ok = (month >= MONTH_FIRST) && (month <= MONTH_LAST);
    m        = month_ok ? month[3:0] : 4'd0;
    mdays    = month_length(m) + 5'((month == MONTH_FEB) && info.leap);
    ok       = (year >= YEAR_BASE) && month_ok && (day != '0)
             && (day <= {2'd0, mdays});

    total = DNUM_W'(year - YEAR_BASE) * DNUM_W'(365)
          + DNUM_W'(info.leaps_before)
          + DNUM_W'(days_before_month(m))
          + DNUM_W'((month > MONTH_FEB) && info.leap)
          + DNUM_W'(day);

    result.date_valid = ok;
    result.day_number = ok ? total : '0;
  end

endmodule
